### rtl/tcu_pkg.sv
// Package for the three-channel timer unit: register map, control bits,
// function codes and the timer update type. No dependencies.
package tcu_pkg;

    localparam int REGISTER_COUNT = 12;
    localparam int IDX_W          = 4;
    localparam int DATA_W         = 16;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  reg_idx_t;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    // Register map
    localparam reg_idx_t T0_CNT  = 4'd0;
    localparam reg_idx_t T0_CMPA = 4'd1;
    localparam reg_idx_t T0_CMPB = 4'd2;
    localparam reg_idx_t T0_CON  = 4'd3;
    localparam reg_idx_t T1_CNT  = 4'd4;
    localparam reg_idx_t T1_CMPA = 4'd5;
    localparam reg_idx_t T1_CMPB = 4'd6;
    localparam reg_idx_t T1_CON  = 4'd7;
    localparam reg_idx_t T2_CNT  = 4'd8;
    localparam reg_idx_t T2_CMPA = 4'd9;
    localparam reg_idx_t T2_CON  = 4'd11;

    // Control word bits
    localparam word_t CON_CONT = 16'h0001;
    localparam word_t CON_ALT  = 16'h0002;
    localparam word_t CON_P    = 16'h0008;
    localparam word_t CON_MC   = 16'h0020;
    localparam word_t CON_RIU  = 16'h1000;
    localparam word_t CON_EN   = 16'h8000;

    typedef struct packed {
        word_t cnt;
        word_t con;
        logic  hit;
    } tmr_upd_t;

endpackage

### rtl/tcu_cmd_if.sv
// Command channel: one transaction is a tick, a register read, a write or a no-op.
// Depends on tcu_pkg.
interface tcu_cmd_if;
    import tcu_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [4:0] port_offset;
    word_t      write_data;

    modport source (output valid, func, port_offset, write_data, input ready);
    modport sink   (input valid, func, port_offset, write_data, output ready);
endinterface

### rtl/tcu_rsp_if.sv
// Response channel: read data and the three timer interrupt pulses.
// Depends on tcu_pkg.
interface tcu_rsp_if;
    import tcu_pkg::*;

    logic  valid;
    logic  ready;
    word_t read_data;
    logic  irq_timer0;
    logic  irq_timer1;
    logic  irq_timer2;

    modport source (output valid, read_data, irq_timer0, irq_timer1, irq_timer2,
                    input ready);
    modport sink   (input valid, read_data, irq_timer0, irq_timer1, irq_timer2,
                    output ready);
endinterface

### rtl/tcu_timer01.sv
// One tick of timer 0 or 1: count, compare against A or B, update control.
// Depends on tcu_pkg.
module tcu_timer01 (
    input  tcu_pkg::word_t    cnt,
    input  tcu_pkg::word_t    cmpa,
    input  tcu_pkg::word_t    cmpb,
    input  tcu_pkg::word_t    con,
    input  logic              t2_pulse,
    output tcu_pkg::tmr_upd_t upd
);
    import tcu_pkg::*;

    word_t cnt_inc;
    word_t cmp_val;
    logic  alt;
    logic  riu;

    assign alt     = |(con & CON_ALT);
    assign riu     = |(con & CON_RIU);
    assign cnt_inc = (!(|(con & CON_P)) || t2_pulse) ? cnt + 16'd1 : cnt;
    assign cmp_val = (alt && riu) ? cmpb : cmpa;

    always_comb
    begin
        upd.cnt = cnt;
        upd.con = con;
        upd.hit = 1'b0;
        if (|(con & CON_EN))
        begin
            upd.cnt = cnt_inc;
            if (cnt_inc == cmp_val)
            begin
                upd.hit = 1'b1;
                upd.cnt = '0;
                upd.con = con | CON_MC;
                if (alt && !riu)
                begin
                    // A reached: switch to B
                    upd.con = upd.con | CON_RIU;
                end
                else
                begin
                    // single compare, or B reached: back to A, stop if one-shot
                    if (alt)
                        upd.con = upd.con & ~CON_RIU;
                    if (!(|(con & CON_CONT)))
                        upd.con = upd.con & ~CON_EN;
                end
            end
        end
    end
endmodule

### rtl/three_channel_timer_unit.sv
// Top level of the three-channel 16-bit timer unit.
// Depends on tcu_pkg, tcu_cmd_if, tcu_rsp_if and tcu_timer01.
//
// Usage:
//   cmd carries one transaction per handshake: func 0 is a timer tick,
//   func 1 reads the register at port_offset >> 1, func 2 writes write_data
//   there; func 3 does nothing. rsp returns exactly one transaction for each
//   command: read_data (zero unless a read of an existing register) and the
//   three interrupt pulses, set only on the tick on which a timer matched.
//   Latency: the response is valid the cycle after the command is taken.
//   Throughput: one command per clock while the receiver keeps up. The register
//   file update, the timer 2 count/compare and the timer 0/1 count/compare are
//   all combinational between acceptance and the response register.
//   Stall: the response register acts as the only buffer; cmd.ready is high
//   whenever that register is empty or is being drained in the same cycle,
//   so a stalled receiver holds the command side after one pending response.
//   Reset (rst_n low, asynchronous): all twelve registers clear to zero and
//   the response register empties.
module three_channel_timer_unit (
    input  logic  clk,
    input  logic  rst_n,
    tcu_cmd_if.sink   cmd,
    tcu_rsp_if.source rsp
);
    import tcu_pkg::*;

    word_t    rf_reg [REGISTER_COUNT];
    word_t    rf_next [REGISTER_COUNT];

    logic     out_valid_reg;
    word_t    rdata_reg, rdata_next;
    logic     irq0_reg, irq0_next;
    logic     irq1_reg, irq1_next;
    logic     irq2_reg, irq2_next;

    logic     accept;
    reg_idx_t idx;
    logic     idx_ok;
    func_t    func;

    // timer 2
    word_t    t2_cnt_inc;
    logic     t2_en;
    logic     t2_hit;

    tmr_upd_t t0_upd;
    tmr_upd_t t1_upd;

    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign idx       = cmd.port_offset[4:1];
    assign idx_ok    = 32'(idx) < REGISTER_COUNT;
    assign func      = func_t'(cmd.func);

    assign t2_en      = |(rf_reg[T2_CON] & CON_EN);
    assign t2_cnt_inc = rf_reg[T2_CNT] + 16'd1;
    assign t2_hit     = t2_en && (t2_cnt_inc == rf_reg[T2_CMPA]);

    tcu_timer01 u_timer1 (
        .cnt      (rf_reg[T1_CNT]),
        .cmpa     (rf_reg[T1_CMPA]),
        .cmpb     (rf_reg[T1_CMPB]),
        .con      (rf_reg[T1_CON]),
        .t2_pulse (t2_hit),
        .upd      (t1_upd)
    );

    tcu_timer01 u_timer0 (
        .cnt      (rf_reg[T0_CNT]),
        .cmpa     (rf_reg[T0_CMPA]),
        .cmpb     (rf_reg[T0_CMPB]),
        .con      (rf_reg[T0_CON]),
        .t2_pulse (t2_hit),
        .upd      (t0_upd)
    );

    always_comb
    begin
        rf_next    = rf_reg;
        rdata_next = '0;
        irq0_next  = 1'b0;
        irq1_next  = 1'b0;
        irq2_next  = 1'b0;
        unique case (func)
            FUNC_TICK:
            begin
                if (t2_en)
                begin
                    rf_next[T2_CNT] = t2_cnt_inc;
                    if (t2_hit)
                    begin
                        rf_next[T2_CNT] = '0;
                        rf_next[T2_CON] = rf_reg[T2_CON] | CON_MC;
                        if (!(|(rf_reg[T2_CON] & CON_CONT)))
                            rf_next[T2_CON] = (rf_reg[T2_CON] | CON_MC) & ~CON_EN;
                    end
                end
                rf_next[T1_CNT] = t1_upd.cnt;
                rf_next[T1_CON] = t1_upd.con;
                rf_next[T0_CNT] = t0_upd.cnt;
                rf_next[T0_CON] = t0_upd.con;
                irq0_next = t0_upd.hit;
                irq1_next = t1_upd.hit;
                irq2_next = t2_hit;
            end
            FUNC_READ:
            begin
                if (idx_ok)
                    rdata_next = rf_reg[idx];
            end
            FUNC_WRITE:
            begin
                if (idx_ok)
                    rf_next[idx] = cmd.write_data;
            end
            default:
            begin
                // unused code: no effect, zero response
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REGISTER_COUNT; i++)
                rf_reg[i] <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                rf_reg        <= rf_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // response payload, loaded with each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= rdata_next;
            irq0_reg  <= irq0_next;
            irq1_reg  <= irq1_next;
            irq2_reg  <= irq2_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = rdata_reg;
    assign rsp.irq_timer0 = irq0_reg;
    assign rsp.irq_timer1 = irq1_reg;
    assign rsp.irq_timer2 = irq2_reg;

endmodule

### test/three_channel_timer_unit_tb.sv
// Testbench for three_channel_timer_unit: directed and random transactions,
// with a scoreboard that predicts every response. Depends on tcu_pkg,
// tcu_cmd_if, tcu_rsp_if and the RTL of the timer unit.
`timescale 1ns / 100ps

module three_channel_timer_unit_tb;
    import tcu_pkg::*;

    // Index 10 is plain storage next to the timer 2 registers.
    localparam reg_idx_t T2_SPARE    = 4'd10;
    // Cycles with no transaction on either channel before the run is abandoned.
    localparam int       STALL_LIMIT = 1000;
    localparam int       LONG_HOLD   = 80;

    typedef struct packed {
        word_t read_data;
        logic  irq_timer0;
        logic  irq_timer1;
        logic  irq_timer2;
    } tcu_rsp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tcu_cmd_if cmd ();
    tcu_rsp_if rsp ();

    three_channel_timer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // Scoreboard state: own copy of the register file and the responses that
    // are still to come, oldest first.
    word_t       shadow_rf [REGISTER_COUNT] = '{default: '0};
    tcu_rsp_t    pending_responses [$];
    int unsigned fail_count   = 0;

    // Traffic shaping, changed by the test sequence.
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned hold_request = 0;

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        fail_count++;
        $display("%0t ns: MISMATCH %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Advances timer 0 or 1; returns the interrupt pulse of this tick.
    function automatic logic step_timer01(input reg_idx_t cnt_i, input reg_idx_t cmpa_i,
                                          input reg_idx_t cmpb_i, input reg_idx_t con_i,
                                          input logic t2_pulse);
        word_t con;
        word_t cnt;
        logic  hit;
        con = shadow_rf[con_i];
        cnt = shadow_rf[cnt_i];
        hit = 1'b0;
        if ((con & CON_EN) == '0)
            return 1'b0;
        // Prescaled timers only move when timer 2 matched on this tick.
        if ((con & CON_P) == '0 || t2_pulse)
            cnt = cnt + 16'd1;
        if ((con & CON_ALT) == '0)
        begin
            if (cnt == shadow_rf[cmpa_i])
            begin
                hit = 1'b1;
                cnt = '0;
                con = con | CON_MC;
                if ((con & CON_CONT) == '0)
                    con = con & ~CON_EN;
            end
        end
        else if ((con & CON_RIU) == '0)
        begin
            // Alternate mode, compare A in use: hand over to B.
            if (cnt == shadow_rf[cmpa_i])
            begin
                hit = 1'b1;
                cnt = '0;
                con = con | CON_MC | CON_RIU;
            end
        end
        else
        begin
            // Alternate mode, compare B in use: back to A, one-shot stops here.
            if (cnt == shadow_rf[cmpb_i])
            begin
                hit = 1'b1;
                cnt = '0;
                con = (con | CON_MC) & ~CON_RIU;
                if ((con & CON_CONT) == '0)
                    con = con & ~CON_EN;
            end
        end
        shadow_rf[cnt_i] = cnt;
        shadow_rf[con_i] = con;
        return hit;
    endfunction

    function automatic tcu_rsp_t timer_unit_step(input func_t f, input logic [4:0] off,
                                                 input word_t wd);
        tcu_rsp_t r;
        reg_idx_t idx;
        word_t    con;
        word_t    cnt;
        r   = '0;
        idx = off[4:1];
        case (f)
            FUNC_TICK:
            begin
                // Timer 2 goes first: its match pulse drives the prescalers.
                con = shadow_rf[T2_CON];
                if ((con & CON_EN) != '0)
                begin
                    cnt = shadow_rf[T2_CNT] + 16'd1;
                    if (cnt == shadow_rf[T2_CMPA])
                    begin
                        cnt = '0;
                        con = con | CON_MC;
                        if ((con & CON_CONT) == '0)
                            con = con & ~CON_EN;
                        r.irq_timer2 = 1'b1;
                    end
                    shadow_rf[T2_CNT] = cnt;
                    shadow_rf[T2_CON] = con;
                end
                r.irq_timer1 = step_timer01(T1_CNT, T1_CMPA, T1_CMPB, T1_CON, r.irq_timer2);
                r.irq_timer0 = step_timer01(T0_CNT, T0_CMPA, T0_CMPB, T0_CON, r.irq_timer2);
            end
            FUNC_READ:
            begin
                if (idx < REGISTER_COUNT)
                    r.read_data = shadow_rf[idx];
            end
            FUNC_WRITE:
            begin
                if (idx < REGISTER_COUNT)
                    shadow_rf[idx] = wd;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: everything is sampled at the rising edge. A response taken
    // here belongs to a command of an earlier edge, so it is checked before
    // this edge's command is predicted.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        tcu_rsp_t seen;
        tcu_rsp_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                seen.read_data  = rsp.read_data;
                seen.irq_timer0 = rsp.irq_timer0;
                seen.irq_timer1 = rsp.irq_timer1;
                seen.irq_timer2 = rsp.irq_timer2;
                if (pending_responses.size() == 0)
                    report_mismatch("response with nothing outstanding", 0, seen);
                else
                begin
                    want = pending_responses.pop_front();
                    if (seen.read_data !== want.read_data)
                        report_mismatch("read_data", want.read_data, seen.read_data);
                    if (seen.irq_timer0 !== want.irq_timer0)
                        report_mismatch("irq_timer0", want.irq_timer0, seen.irq_timer0);
                    if (seen.irq_timer1 !== want.irq_timer1)
                        report_mismatch("irq_timer1", want.irq_timer1, seen.irq_timer1);
                    if (seen.irq_timer2 !== want.irq_timer2)
                        report_mismatch("irq_timer2", want.irq_timer2, seen.irq_timer2);
                end
            end
            if (cmd.valid && cmd.ready)
                pending_responses.push_back(timer_unit_step(func_t'(cmd.func),
                                                            cmd.port_offset,
                                                            cmd.write_data));
        end
    end

    // ------------------------------------------------------------------
    // Response side: random ready at the falling edge, or a long hold-off
    // when the test sequence asks for one.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Watchdog: ends the run if traffic stops on both channels.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Byte offset of a register; the low bit is don't-care to the decode.
    function automatic logic [4:0] offset_of(input reg_idx_t idx);
        return {idx, 1'($urandom_range(1))};
    endfunction

    // Offers one transaction from a falling edge and returns at the falling
    // edge after it was taken. valid stays high so back-to-back commands
    // need no gap.
    task automatic send_cmd(input func_t f, input logic [4:0] off, input word_t wd);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid       <= 1'b1;
        cmd.func        <= f;
        cmd.port_offset <= off;
        cmd.write_data  <= wd;
        do
            @(posedge clk);
        while (!cmd.ready);
        @(negedge clk);
    endtask

    // Stops offering and waits until every response is back. Always waits for a
    // falling edge so valid is never lowered and raised in one step.
    task automatic drain_responses();
        cmd.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_responses.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Everything reads as zero after reset, including past the register file.
    task automatic test_reset_values();
        send_cmd(FUNC_READ, offset_of(T0_CON), 16'h0000);
        send_cmd(FUNC_READ, offset_of(T2_CON), 16'hFFFF);
        send_cmd(FUNC_READ, offset_of(T2_SPARE), 16'h0000);
        send_cmd(FUNC_READ, 5'd31, 16'hFFFF);
    endtask

    // Index decode, spare storage, writes past the end, unused function.
    task automatic test_register_decode();
        send_cmd(FUNC_WRITE, offset_of(T2_SPARE), 16'hFFFF);
        send_cmd(FUNC_READ, offset_of(T2_SPARE), 16'h0000);
        send_cmd(FUNC_WRITE, {T1_CMPB, 1'b1}, 16'h5A5A);
        send_cmd(FUNC_READ, {T1_CMPB, 1'b0}, 16'h0000);
        send_cmd(FUNC_WRITE, 5'd24, 16'hFFFF);
        send_cmd(FUNC_READ, 5'd25, 16'h0000);
        send_cmd(FUNC_NOP, 5'd31, 16'hFFFF);
    endtask

    // Timer 2 continuous, timer 1 alternating A/B, timer 0 prescaled one-shot.
    task automatic test_timer_modes();
        send_cmd(FUNC_WRITE, offset_of(T2_CMPA), 16'd2);
        send_cmd(FUNC_WRITE, offset_of(T2_CON), CON_EN | CON_CONT);
        send_cmd(FUNC_WRITE, offset_of(T1_CMPA), 16'd1);
        send_cmd(FUNC_WRITE, offset_of(T1_CMPB), 16'd2);
        send_cmd(FUNC_WRITE, offset_of(T1_CON), CON_EN | CON_ALT | CON_CONT);
        send_cmd(FUNC_WRITE, offset_of(T0_CMPA), 16'd1);
        send_cmd(FUNC_WRITE, offset_of(T0_CON), CON_EN | CON_P);
        repeat (4)
            send_cmd(FUNC_TICK, 5'd0, 16'h0000);
        send_cmd(FUNC_READ, offset_of(T0_CON), 16'h0000);
    endtask

    // Count wraps from 0xFFFF to zero and then matches a compare of zero.
    task automatic test_counter_wrap();
        send_cmd(FUNC_WRITE, offset_of(T2_CON), 16'h0000);
        send_cmd(FUNC_WRITE, offset_of(T0_CNT), 16'hFFFF);
        send_cmd(FUNC_WRITE, offset_of(T0_CMPA), 16'h0000);
        send_cmd(FUNC_WRITE, offset_of(T0_CON), CON_EN);
        send_cmd(FUNC_TICK, 5'd31, 16'hFFFF);
    endtask

    // Receiver holds off for a long stretch while ticks keep coming, so the
    // single response register fills and cmd.ready drops. Afterwards the
    // sender pauses until every response has come back.
    task automatic test_backpressure();
        drain_responses();
        @(posedge clk);
        hold_request = LONG_HOLD;
        @(negedge clk);
        repeat (12)
            send_cmd(FUNC_TICK, 5'($urandom_range(31)), 16'($urandom));
        drain_responses();
    endtask

    // Data for a register write, biased toward values timers actually reach.
    function automatic word_t random_word(input reg_idx_t idx);
        word_t w;
        if (idx == T0_CON || idx == T1_CON || idx == T2_CON)
        begin
            w = 16'($urandom);
            if ($urandom_range(9) < 7)
                w = w | CON_EN;
            return w;
        end
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return 16'($urandom_range(15));
            6, 7:             return 16'hFFF0 | 16'($urandom_range(15));
            default:          return 16'($urandom);
        endcase
    endfunction

    // Well-formed setup of one timer: count, compares, then the control word.
    task automatic program_random_timer();
        reg_idx_t cnt_i;
        reg_idx_t cmpa_i;
        reg_idx_t cmpb_i;
        reg_idx_t con_i;
        word_t    con;
        case ($urandom_range(2))
            0:
            begin
                cnt_i = T0_CNT; cmpa_i = T0_CMPA; cmpb_i = T0_CMPB; con_i = T0_CON;
            end
            1:
            begin
                cnt_i = T1_CNT; cmpa_i = T1_CMPA; cmpb_i = T1_CMPB; con_i = T1_CON;
            end
            default:
            begin
                cnt_i = T2_CNT; cmpa_i = T2_CMPA; cmpb_i = T2_SPARE; con_i = T2_CON;
            end
        endcase
        con = CON_EN | (16'($urandom) & (CON_CONT | CON_ALT | CON_P | CON_RIU | CON_MC));
        send_cmd(FUNC_WRITE, offset_of(cnt_i), ($urandom_range(3) == 0) ? 16'hFFFE : 16'h0000);
        send_cmd(FUNC_WRITE, offset_of(cmpa_i), 16'($urandom_range(8, 1)));
        send_cmd(FUNC_WRITE, offset_of(cmpb_i), 16'($urandom_range(8, 1)));
        send_cmd(FUNC_WRITE, offset_of(con_i), con);
    endtask

    // One random step; counted is low for transactions the block ignores.
    task automatic random_command(output bit counted);
        int unsigned pick;
        reg_idx_t    idx;
        pick    = $urandom_range(99);
        counted = 1'b1;
        if (pick < 8)
            program_random_timer();
        else if (pick < 58)
            send_cmd(FUNC_TICK, 5'($urandom_range(31)), 16'($urandom));
        else if (pick < 73)
            send_cmd(FUNC_READ, 5'($urandom_range(31)), 16'($urandom));
        else if (pick < 95)
        begin
            idx = 4'($urandom_range(REGISTER_COUNT - 1));
            send_cmd(FUNC_WRITE, offset_of(idx), random_word(idx));
        end
        else
        begin
            counted = 1'b0;
            if (pick < 98)
                send_cmd(FUNC_NOP, 5'($urandom_range(31)), 16'($urandom));
            else
                send_cmd(FUNC_WRITE, 5'($urandom_range(31, 24)), 16'($urandom));
        end
    endtask

    task automatic test_random(input int unsigned count);
        int unsigned done;
        bit          counted;
        done = 0;
        while (done < count)
        begin
            random_command(counted);
            done += counted;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        cmd.valid       <= 1'b0;
        cmd.func        <= FUNC_NOP;
        cmd.port_offset <= '0;
        cmd.write_data  <= '0;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;

        // Sender sparse-ish, receiver stalls often.
        snd_idle_pct = 24;
        rcv_idle_pct = 45;
        test_reset_values();
        test_register_decode();
        test_timer_modes();
        test_counter_wrap();
        test_backpressure();
        test_random(300);

        // Roles swapped.
        snd_idle_pct = 45;
        rcv_idle_pct = 24;
        test_random(300);

        // Full rate on both sides.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random(300);

        // Response comes in the cycle after the command; the idle wait after the
        // drain catches any stray extra response.
        drain_responses();
        repeat (4)
            @(negedge clk);
        if (fail_count == 0 && pending_responses.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
